FILE: rtl/char_lcd_bus_write_sequencer_unit_assert.svh
// assertion helpers for the lcd bus write sequencer
// both expect clk and rst to be in scope
`ifndef CHAR_LCD_BUS_WRITE_SEQUENCER_UNIT_ASSERT_SVH
`define CHAR_LCD_BUS_WRITE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define LCDSEQ_ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define LCDSEQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_DATA   = 3'd2,
    OP_GOTO   = 3'd3,
    OP_NUMBER = 3'd4
  } lcdseq_op_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         byte_value;
    logic [3:0]         row;
    logic [4:0]         column;
    logic signed [15:0] number;
  } lcdseq_req_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_value;
    logic [5:0] wait_before_ms;
    logic [4:0] settle_ms;
    logic       last;
  } lcdseq_strobe_t;

  // one byte to be written, before it is split into strobes
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic [5:0] wait_ms;
    logic [1:0] extra_ms;
    logic       one_strobe;
  } lcdseq_desc_t;

  typedef struct packed {
    logic       load_req;
    logic       conv_step;
    logic       emit;
    logic [2:0] byte_idx;
    logic       nib_lo;
    logic       last;
  } lcdseq_cmd_t;

  typedef struct packed {
    logic       is_num;
    logic       mag_lt10;
    logic [2:0] byte_count;
    logic       two_strobes;
    logic       out_free;
  } lcdseq_status_t;

  localparam logic [7:0]  FUNC_SET_8    = 8'h38;
  localparam logic [7:0]  FUNC_SET_4    = 8'h28;
  localparam logic [7:0]  WAKE_4BIT     = 8'h20;
  localparam logic [7:0]  DISPLAY_ON    = 8'h0F;
  localparam logic [7:0]  CLEAR_DISPLAY = 8'h01;
  localparam logic [7:0]  ENTRY_MODE    = 8'h06;
  localparam logic [7:0]  ROW1_BASE     = 8'h80;
  localparam logic [7:0]  ROW2_BASE     = 8'hC0;
  localparam logic [7:0]  CHAR_MINUS    = 8'h2D;
  localparam logic [7:0]  CHAR_ZERO     = 8'h30;
  localparam logic [5:0]  POWER_UP_WAIT = 6'd35;
  localparam logic [4:0]  BYTE_SETTLE   = 5'd20;
  localparam logic [4:0]  NIBBLE_SETTLE = 5'd5;
  localparam logic [15:0] DEC_BASE      = 16'd10;
  localparam logic [16:0] DIV10_RECIP   = 17'd52429;
  localparam int          DIV10_SHIFT   = 19;
  localparam logic [2:0]  MAX_DIGITS    = 3'd5;
  localparam logic [2:0]  INIT_BYTES_8  = 3'd4;
  localparam logic [2:0]  INIT_BYTES_4  = 3'd5;

  // init byte list; four-bit mode starts with a single wake strobe
  function automatic lcdseq_desc_t init_desc(input logic [2:0] idx, input logic nibble_bus);
    lcdseq_desc_t d;
    logic [2:0]   k;
    d = '0;
    k = nibble_bus ? idx - 3'd1 : idx;
    if (nibble_bus && idx == 3'd0) begin
      d.value      = WAKE_4BIT;
      d.one_strobe = 1'b1;
    end else begin
      case (k)
        3'd0: begin
          d.value   = nibble_bus ? FUNC_SET_4 : FUNC_SET_8;
          d.wait_ms = nibble_bus ? 6'd0 : POWER_UP_WAIT;
        end
        3'd1: begin
          d.value    = DISPLAY_ON;
          d.extra_ms = 2'd1;
        end
        3'd2: begin
          d.value    = CLEAR_DISPLAY;
          d.extra_ms = 2'd2;
        end
        3'd3: begin
          d.value    = ENTRY_MODE;
          d.extra_ms = 2'd1;
        end
        default: d = '0;
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lcdseq_ctrl.sv
`default_nettype none

module lcdseq_ctrl import lcdseq_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lcdseq_status_t status,
  output lcdseq_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_CONV,
    S_EMIT
  } state_t;

  state_t     state;
  logic [2:0] byte_idx;
  logic       nib_lo;
  logic       last_byte;

  assign in_ready  = (state == S_IDLE);
  assign last_byte = (byte_idx == status.byte_count - 3'd1);

  always_comb begin
    cmd           = '0;
    cmd.load_req  = in_ready && in_valid;
    cmd.conv_step = (state == S_CONV);
    cmd.emit      = (state == S_EMIT) && (status.byte_count != 3'd0) && status.out_free;
    cmd.byte_idx  = byte_idx;
    cmd.nib_lo    = nib_lo;
    cmd.last      = last_byte && (!status.two_strobes || nib_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      byte_idx <= '0;
      nib_lo   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          byte_idx <= '0;
          nib_lo   <= 1'b0;
          if (cmd.load_req) state <= S_START;
        end
        S_START: begin
          state <= status.is_num ? S_CONV : S_EMIT;
        end
        S_CONV: begin
          if (status.mag_lt10) state <= S_EMIT;
        end
        S_EMIT: begin
          if (status.byte_count == 3'd0) begin
            state <= S_IDLE;
          end else if (cmd.emit) begin
            if (cmd.last) begin
              state <= S_IDLE;
            end else if (status.two_strobes && !nib_lo) begin
              nib_lo <= 1'b1;
            end else begin
              nib_lo   <= 1'b0;
              byte_idx <= byte_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "char_lcd_bus_write_sequencer_unit_assert.svh"

  `LCDSEQ_ASSERT_SAME(a_idle_no_emit, state == S_IDLE, !cmd.emit, "strobe issued while idle")
  `LCDSEQ_ASSERT_NEXT(a_last_to_idle, cmd.emit && cmd.last, state == S_IDLE, "no idle after last")
  `LCDSEQ_ASSERT_SAME(a_low_nibble_mode, cmd.emit && cmd.nib_lo, status.two_strobes,
                      "low nibble in byte mode")
  `LCDSEQ_ASSERT_SAME(a_idx_range, cmd.emit, byte_idx < status.byte_count,
                      "byte index past end of request")

endmodule

`default_nettype wire

FILE: rtl/lcdseq_dp.sv
`default_nettype none

module lcdseq_dp import lcdseq_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire lcdseq_req_t    in_req,
  input  wire lcdseq_cmd_t    cmd,
  output lcdseq_status_t      status,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lcdseq_strobe_t      out_strobe
);

  logic          bus_mode;
  lcdseq_req_t   req;
  logic [15:0]   mag;
  logic [2:0]    ndig;
  logic [3:0]    dig [MAX_DIGITS];
  logic [32:0]   prod;
  logic [15:0]   quo;
  logic [15:0]   rem_full;
  logic [15:0]   in_mag;
  logic          neg;
  logic [2:0]    didx;
  logic [3:0]    dval;
  logic [2:0]    cnt;
  lcdseq_desc_t  desc;
  logic          two;

  // divide by ten through the reciprocal
  assign prod     = {17'd0, mag} * {16'd0, DIV10_RECIP};
  assign quo      = 16'(prod >> DIV10_SHIFT);
  assign rem_full = mag - ((quo << 3) + (quo << 1));
  assign in_mag   = in_req.number[15] ? 16'(-in_req.number) : 16'(in_req.number);
  assign neg      = req.number[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      bus_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req  <= in_req;
      mag  <= in_mag;
      ndig <= '0;
    end else if (cmd.conv_step) begin
      dig[ndig] <= rem_full[3:0];
      mag       <= quo;
      ndig      <= ndig + 3'd1;
    end
  end

  always_comb begin
    didx = ndig - 3'd1 - (cmd.byte_idx - {2'b00, neg});
    dval = (didx < MAX_DIGITS) ? dig[didx] : 4'd0;
    desc = '0;
    cnt  = '0;
    case (req.opcode)
      OP_INIT: begin
        desc = init_desc(cmd.byte_idx, bus_mode);
        cnt  = bus_mode ? INIT_BYTES_4 : INIT_BYTES_8;
      end
      OP_CMD: begin
        desc.value = req.byte_value;
        cnt        = 3'd1;
      end
      OP_DATA: begin
        desc.rs    = 1'b1;
        desc.value = req.byte_value;
        cnt        = 3'd1;
      end
      OP_GOTO: begin
        if (req.row >= 4'd1 && req.row <= 4'd2 && req.column >= 5'd1 && req.column <= 5'd16)
        begin
          desc.value = ((req.row == 4'd1) ? ROW1_BASE : ROW2_BASE)
                       + {3'b000, req.column} - 8'd1;
          cnt        = 3'd1;
        end
      end
      OP_NUMBER: begin
        desc.rs    = 1'b1;
        desc.value = (neg && cmd.byte_idx == 3'd0) ? CHAR_MINUS : CHAR_ZERO + {4'd0, dval};
        cnt        = ndig + {2'b00, neg};
      end
      default: cnt = '0;
    endcase
  end

  assign two = bus_mode && !desc.one_strobe;

  always_comb begin
    status             = '0;
    status.is_num      = (req.opcode == OP_NUMBER);
    status.mag_lt10    = (mag < DEC_BASE);
    status.byte_count  = cnt;
    status.two_strobes = two;
    status.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_strobe.register_select <= desc.rs;
      out_strobe.last            <= cmd.last;
      if (!two) begin
        out_strobe.bus_value      <= desc.value;
        out_strobe.wait_before_ms <= desc.wait_ms;
        out_strobe.settle_ms      <= BYTE_SETTLE + {3'b000, desc.extra_ms};
      end else if (!cmd.nib_lo) begin
        out_strobe.bus_value      <= {desc.value[7:4], 4'b0000};
        out_strobe.wait_before_ms <= desc.wait_ms;
        out_strobe.settle_ms      <= NIBBLE_SETTLE;
      end else begin
        out_strobe.bus_value      <= {desc.value[3:0], 4'b0000};
        out_strobe.wait_before_ms <= 6'd0;
        out_strobe.settle_ms      <= NIBBLE_SETTLE + {3'b000, desc.extra_ms};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/char_lcd_bus_write_sequencer_unit.sv
// the first strobe is registered in the emit state, after the start state and,
// for numbers, the digit conversion (one decimal digit per cycle through the
// divide-by-ten multiplier)
// throughput: one strobe per cycle while the receiver takes them, up to 12 per
// request; the next request is taken only once the previous one is done
// reset: rst synchronous active high, bus_mode returns to four-bit nibble mode
`default_nettype none

module char_lcd_bus_write_sequencer_unit import lcdseq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: bus_mode register, 0 eight-bit, 1 four-bit
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire lcdseq_req_t in_req,
  // strobe channel, one strobe per valid/ready handshake
  output logic             out_valid,
  input  wire logic        out_ready,
  output lcdseq_strobe_t   out_strobe
);

  // command and status between the sequencer fsm and the datapath
  lcdseq_cmd_t    cmd;
  lcdseq_status_t status;

  // fsm: idle -> start -> (digit conversion for numbers) -> emit strobes
  // a request is taken only in idle; the output register lets the last
  // strobe wait downstream while the next request comes in
  lcdseq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: request register, decimal digit extraction, byte list
  // selection, nibble split and the output strobe register
  lcdseq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_strobe  (out_strobe)
  );

endmodule

`default_nettype wire

FILE: tb/char_lcd_bus_write_sequencer_unit_test.sv
module char_lcd_bus_write_sequencer_unit_test import lcdseq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int CYCLE_LIMIT     = 300000;
  // the longest internal run of a request fits well inside this drain time
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_AFTER_REQS = 150;
  localparam int HOLD_CYCLES     = 400;
  localparam int RANDOM_PER_PHASE = 88;
  localparam int LAST_COL        = 16;

  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_wr_en = 1'b0;
  logic           cfg_wr_data = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  lcdseq_req_t    in_req = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  lcdseq_strobe_t out_strobe;

  // requests waiting for the driver, strobes waiting for the bus
  lcdseq_req_t    req_backlog [$];
  lcdseq_strobe_t strobe_expect [$];
  lcdseq_strobe_t want;

  // our own copy of bus_mode, follows every register write
  logic nibble_mode = 1'b1;

  logic req_fire = 1'b0;
  int   cycle_count = 0;
  int   reqs_taken = 0;
  int   mismatch_count = 0;

  // sender burst state
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall state
  int rx_cycle = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int num_edges [12] = '{-32768, 32767, -1, 0, 1, 9, 10, -10, 99, 100, 9999, 10000};

  char_lcd_bus_write_sequencer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_strobe (out_strobe)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------
  // strobe prediction
  // ---------------------------------------------------------------

  task automatic push_strobe(input logic rs, input logic [7:0] bv,
                             input logic [5:0] wait_ms, input logic [4:0] settle);
    lcdseq_strobe_t s;
    s.register_select = rs;
    s.bus_value       = bv;
    s.wait_before_ms  = wait_ms;
    s.settle_ms       = settle;
    s.last            = 1'b0;
    strobe_expect.push_back(s);
  endtask

  // one byte: a single strobe on an eight-bit bus, high then low nibble on
  // a four-bit bus; the extra settle time lands on the final strobe
  task automatic push_byte(input logic rs, input logic [7:0] b,
                           input logic [5:0] wait_ms, input logic [4:0] extra);
    if (!nibble_mode) begin
      push_strobe(rs, b, wait_ms, BYTE_SETTLE + extra);
    end else begin
      push_strobe(rs, {b[7:4], 4'h0}, wait_ms, NIBBLE_SETTLE);
      push_strobe(rs, {b[3:0], 4'h0}, 6'd0, NIBBLE_SETTLE + extra);
    end
  endtask

  task automatic predict_strobes(input lcdseq_req_t r);
    int         first;
    int         mag;
    int         nd;
    bit         neg;
    logic [3:0] dig [5];
    first = strobe_expect.size();
    case (r.opcode)
      OP_INIT: begin
        if (!nibble_mode) begin
          push_byte(1'b0, FUNC_SET_8, POWER_UP_WAIT, 5'd0);
        end else begin
          // lone wake strobe puts the controller into four-bit mode
          push_strobe(1'b0, WAKE_4BIT, 6'd0, BYTE_SETTLE);
          push_byte(1'b0, FUNC_SET_4, 6'd0, 5'd0);
        end
        push_byte(1'b0, DISPLAY_ON, 6'd0, 5'd1);
        push_byte(1'b0, CLEAR_DISPLAY, 6'd0, 5'd2);
        push_byte(1'b0, ENTRY_MODE, 6'd0, 5'd1);
      end
      OP_CMD:  push_byte(1'b0, r.byte_value, 6'd0, 5'd0);
      OP_DATA: push_byte(1'b1, r.byte_value, 6'd0, 5'd0);
      OP_GOTO: begin
        // out-of-range row or column is silently dropped
        if (r.row >= 1 && r.row <= 2 && r.column >= 1 && r.column <= LAST_COL) begin
          push_byte(1'b0, 8'(((r.row == 4'd1) ? ROW1_BASE : ROW2_BASE) + r.column - 1),
                    6'd0, 5'd0);
        end
      end
      OP_NUMBER: begin
        mag = $signed(r.number);
        neg = (mag < 0);
        if (neg) begin
          mag = -mag;  // -32768 fits fine in an int
        end
        if (mag == 0) begin
          push_byte(1'b1, CHAR_ZERO, 6'd0, 5'd0);
        end else begin
          nd = 0;
          while (mag != 0) begin
            dig[nd] = 4'(mag % 10);
            mag     = mag / 10;
            nd++;
          end
          if (neg) begin
            push_byte(1'b1, CHAR_MINUS, 6'd0, 5'd0);
          end
          while (nd > 0) begin
            nd--;
            push_byte(1'b1, CHAR_ZERO + 8'(dig[nd]), 6'd0, 5'd0);
          end
        end
      end
      default: ;
    endcase
    if (strobe_expect.size() > first) begin
      strobe_expect[strobe_expect.size() - 1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------
  // request driver: bursts of random length with random gaps,
  // payload held steady until the handshake
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (req_backlog.size() > 0) begin
        in_req   <= req_backlog.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          // some bursts run back to back with no gap at all
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // strobe receiver: stall style steps through four patterns, plus one long
  // hold-off so the block backs up and drops in_ready
  // ---------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && reqs_taken >= HOLD_AFTER_REQS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= (rx_cycle % 3 != 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
    rx_cycle = rx_cycle + 1;
  end

  // ---------------------------------------------------------------
  // monitor: tracks the register, predicts on each accepted request,
  // checks each accepted strobe against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    req_fire    <= !rst && in_valid && in_ready;
    if (rst) begin
      nibble_mode = 1'b1;
    end else begin
      if (cfg_wr_en) begin
        nibble_mode = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        predict_strobes(in_req);
        reqs_taken = reqs_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (strobe_expect.size() == 0) begin
          $error("unexpected strobe: bus_value %02h", out_strobe.bus_value);
          mismatch_count++;
        end else begin
          want = strobe_expect.pop_front();
          if (out_strobe.register_select !== want.register_select) begin
            $error("register_select: expected %0d, got %0d",
                   want.register_select, out_strobe.register_select);
            mismatch_count++;
          end
          if (out_strobe.bus_value !== want.bus_value) begin
            $error("bus_value: expected %02h, got %02h", want.bus_value, out_strobe.bus_value);
            mismatch_count++;
          end
          if (out_strobe.wait_before_ms !== want.wait_before_ms) begin
            $error("wait_before_ms: expected %0d, got %0d",
                   want.wait_before_ms, out_strobe.wait_before_ms);
            mismatch_count++;
          end
          if (out_strobe.settle_ms !== want.settle_ms) begin
            $error("settle_ms: expected %0d, got %0d", want.settle_ms, out_strobe.settle_ms);
            mismatch_count++;
          end
          if (out_strobe.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_strobe.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------

  function automatic lcdseq_req_t mk_req(input logic [2:0] op, input logic [7:0] bv,
                                         input logic [3:0] row, input logic [4:0] col,
                                         input int num);
    lcdseq_req_t r;
    r.opcode     = op;
    r.byte_value = bv;
    r.row        = row;
    r.column     = col;
    r.number     = 16'(num);
    return r;
  endfunction

  // field extremes, every opcode, rejected goto, number corner cases
  task automatic queue_directed();
    req_backlog.push_back(mk_req(OP_INIT,   8'h00, 4'd0,  5'd0,  0));
    req_backlog.push_back(mk_req(OP_CMD,    8'hFF, 4'd0,  5'd0,  0));
    req_backlog.push_back(mk_req(OP_DATA,   8'h00, 4'd15, 5'd31, -1));
    req_backlog.push_back(mk_req(OP_GOTO,   8'h00, 4'd1,  5'd1,  0));
    req_backlog.push_back(mk_req(OP_GOTO,   8'h00, 4'd2,  5'd16, 0));
    req_backlog.push_back(mk_req(OP_GOTO,   8'h00, 4'd0,  5'd5,  0));
    req_backlog.push_back(mk_req(OP_GOTO,   8'h00, 4'd1,  5'd17, 0));
    req_backlog.push_back(mk_req(OP_NUMBER, 8'h00, 4'd0,  5'd0,  0));
    req_backlog.push_back(mk_req(OP_NUMBER, 8'h00, 4'd0,  5'd0,  -32768));
    req_backlog.push_back(mk_req(OP_NUMBER, 8'h00, 4'd0,  5'd0,  32767));
    req_backlog.push_back(mk_req(OP_NUMBER, 8'h00, 4'd0,  5'd0,  -9));
    req_backlog.push_back(mk_req(OP_SPARE_LO, 8'hFF, 4'd1, 5'd1, 5));
    req_backlog.push_back(mk_req(OP_SPARE_HI, 8'h00, 4'd2, 5'd2, 5));
  endtask

  // mostly meaningful requests with random content; ignored ones are mixed
  // in but do not count toward the total
  task automatic queue_random(input int count);
    lcdseq_req_t r;
    int          got;
    int          pick;
    int          v;
    got = 0;
    while (got < count) begin
      r.byte_value = 8'($urandom);
      r.row        = 4'($urandom);
      r.column     = 5'($urandom);
      r.number     = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        r.opcode = OP_INIT;
      end else if (pick < 25) begin
        r.opcode = OP_CMD;
      end else if (pick < 45) begin
        r.opcode = OP_DATA;
      end else if (pick < 70) begin
        r.opcode = OP_GOTO;
        if ($urandom_range(0, 4) != 0) begin
          r.row    = 4'($urandom_range(1, 2));
          r.column = 5'($urandom_range(1, LAST_COL));
        end
      end else if (pick < 95) begin
        r.opcode = OP_NUMBER;
        case ($urandom_range(0, 3))
          0: ;  // full 16-bit range as drawn
          1: r.number = 16'($urandom_range(0, 198) - 99);
          2: r.number = 16'(num_edges[$urandom_range(0, 11)]);
          default: begin
            v = $urandom_range(0, 9999);
            r.number = 16'(($urandom_range(0, 1) == 0) ? v : -v);
          end
        endcase
      end else begin
        r.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      req_backlog.push_back(r);
      if (r.opcode <= OP_NUMBER &&
          !(r.opcode == OP_GOTO &&
            !(r.row >= 1 && r.row <= 2 && r.column >= 1 && r.column <= LAST_COL))) begin
        got++;
      end
    end
  endtask

  // everything sent, everything seen, then room for a dropped request
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (req_backlog.size() != 0 || in_valid || strobe_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bus_mode(input logic nibble_bus);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= nibble_bus;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed pass on each bus width
    write_bus_mode(1'b0);
    queue_directed();
    wait_idle();
    write_bus_mode(1'b1);
    queue_directed();
    wait_idle();

    // random phases, flipping the bus width in between
    write_bus_mode(1'b0);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();
    write_bus_mode(1'b1);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();
    write_bus_mode(1'b0);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();
    write_bus_mode(1'b1);
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    if (mismatch_count == 0 && strobe_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run-away guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lcdseq_pkg.sv
rtl/lcdseq_ctrl.sv
rtl/lcdseq_dp.sv
rtl/char_lcd_bus_write_sequencer_unit.sv
tb/char_lcd_bus_write_sequencer_unit_test.sv
